FILE: design/ipv6ecp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ipv6ecp_pkg;

   // item kinds on the request channel
   localparam logic [1:0] KIND_START   = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_END     = 2'd2;

   // final status codes
   localparam logic [2:0] ST_COMPLETE    = 3'd0;
   localparam logic [2:0] ST_NO_NEXT     = 3'd1;
   localparam logic [2:0] ST_UNSUPPORTED = 3'd2;
   localparam logic [2:0] ST_MALFORMED   = 3'd3;
   localparam logic [2:0] ST_LIMIT       = 3'd4;

   // protocol numbers
   localparam logic [7:0] PROTO_HOP_BY_HOP = 8'd0;
   localparam logic [7:0] PROTO_TCP        = 8'd6;
   localparam logic [7:0] PROTO_UDP        = 8'd17;
   localparam logic [7:0] PROTO_ROUTING    = 8'd43;
   localparam logic [7:0] PROTO_FRAG       = 8'd44;
   localparam logic [7:0] PROTO_ICMPV6     = 8'd58;
   localparam logic [7:0] PROTO_NO_NEXT    = 8'd59;
   localparam logic [7:0] PROTO_DEST_OPTS  = 8'd60;

   localparam logic [11:0] FRAG_HDR_LEN = 12'd8;

   // configuration register indexes
   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CSR_HEADER_LIMIT = 1'd0;
   localparam csr_index_type CSR_BYTE_BUDGET  = 1'd1;
   localparam int CSR_DATA_W = 16;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic [7:0] first_header_type;
   } req_type;

   typedef struct packed {
      logic        record_type;
      logic [7:0]  header_type;
      logic [7:0]  following_header;
      logic [15:0] header_offset;
      logic [11:0] header_length;
      logic [12:0] frag_offset;
      logic        more_frags;
      logic [31:0] frag_ident;
      logic [2:0]  status;
      logic [7:0]  final_header;
      logic [15:0] walked_bytes;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  header_limit;
      logic [15:0] byte_budget;
   } csr_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } rsp_push_type;

endpackage

`default_nettype wire

FILE: design/ipv6ecp_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module ipv6ecp_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_write,
   input  wire ipv6ecp_pkg::csr_index_type  csr_index,
   input  wire logic [ipv6ecp_pkg::CSR_DATA_W-1:0] csr_wdata,
   output ipv6ecp_pkg::csr_type             cfg
);
   import ipv6ecp_pkg::*;

   logic [7:0]  header_limit_ff;
   logic [15:0] byte_budget_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_limit_ff <= 8'd8;
         byte_budget_ff  <= 16'd2048;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_HEADER_LIMIT: header_limit_ff <= csr_wdata[7:0];
            CSR_BYTE_BUDGET:  byte_budget_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign cfg.header_limit = header_limit_ff;
   assign cfg.byte_budget  = byte_budget_ff;

endmodule

`default_nettype wire

FILE: design/ipv6ecp_walker.sv
`timescale 1ns / 1ps
`default_nettype none

module ipv6ecp_walker #(
   parameter int MAX_PAYLOAD_BYTES = 65535
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire ipv6ecp_pkg::req_type     req,
   input  wire ipv6ecp_pkg::csr_type     cfg,
   output ipv6ecp_pkg::rsp_push_type     push
);
   import ipv6ecp_pkg::*;

   localparam logic [16:0] PAYLOAD_CAP = 17'(MAX_PAYLOAD_BYTES);

   logic [7:0]  current_type_ff,   current_type_in;
   logic [15:0] chain_offset_ff,   chain_offset_in;
   logic [7:0]  header_count_ff,   header_count_in;
   logic [10:0] byte_in_header_ff, byte_in_header_in;
   logic [11:0] current_length_ff, current_length_in;
   logic [7:0]  inner_next_ff,     inner_next_in;
   logic [15:0] frag_word_ff,      frag_word_in;
   logic [31:0] ident_word_ff,     ident_word_in;
   logic [2:0]  decided_status_ff, decided_status_in;
   logic        decided_flag_ff,   decided_flag_in;

   logic [15:0] budget_left;
   logic        is_ext;
   logic        is_frag;
   logic        chk_hit;
   logic [2:0]  chk_status;
   logic [11:0] bih_next;
   logic        past_cap;
   logic [11:0] byte1_len;
   logic [11:0] cur_len;
   logic        hdr_done;
   logic [2:0]  end_status;

   always_comb begin
      budget_left = (cfg.byte_budget > chain_offset_ff) ?
                    cfg.byte_budget - chain_offset_ff : 16'd0;
      is_ext  = current_type_ff inside {PROTO_HOP_BY_HOP, PROTO_ROUTING,
                                        PROTO_FRAG, PROTO_DEST_OPTS};
      is_frag = (current_type_ff == PROTO_FRAG);

      // header start checks, in priority order
      chk_hit    = 1'b1;
      chk_status = ST_LIMIT;
      if (header_count_ff == 8'd0 &&
          (cfg.header_limit == 8'd0 || cfg.byte_budget == 16'd0)) begin
         chk_status = ST_LIMIT;
      end else if (!is_ext) begin
         if (current_type_ff == PROTO_NO_NEXT)
            chk_status = ST_NO_NEXT;
         else if (current_type_ff inside {PROTO_TCP, PROTO_UDP, PROTO_ICMPV6})
            chk_status = ST_COMPLETE;
         else
            chk_status = ST_UNSUPPORTED;
      end else if (header_count_ff >= cfg.header_limit ||
                   chain_offset_ff >= cfg.byte_budget) begin
         chk_status = ST_LIMIT;
      end else if (budget_left < 16'd2) begin
         chk_status = ST_MALFORMED;
      end else begin
         chk_hit = 1'b0;
      end

      bih_next  = {1'b0, byte_in_header_ff} + 12'd1;
      past_cap  = ({1'b0, chain_offset_ff} + {6'd0, byte_in_header_ff}) >= PAYLOAD_CAP;
      byte1_len = {({1'b0, req.data_byte} + 9'd1), 3'b000};
      cur_len   = (byte_in_header_ff == 11'd1 && !is_frag) ? byte1_len
                                                           : current_length_ff;
      hdr_done  = (bih_next >= cur_len);
      end_status = (byte_in_header_ff == 11'd0 && chk_hit) ? chk_status : ST_MALFORMED;
   end

   always_comb begin
      current_type_in   = current_type_ff;
      chain_offset_in   = chain_offset_ff;
      header_count_in   = header_count_ff;
      byte_in_header_in = byte_in_header_ff;
      current_length_in = current_length_ff;
      inner_next_in     = inner_next_ff;
      frag_word_in      = frag_word_ff;
      ident_word_in     = ident_word_ff;
      decided_status_in = decided_status_ff;
      decided_flag_in   = decided_flag_ff;
      push              = '0;

      if (accept) begin
         case (req.kind)
            KIND_START: begin
               current_type_in   = req.first_header_type;
               chain_offset_in   = '0;
               header_count_in   = '0;
               byte_in_header_in = '0;
               current_length_in = '0;
               inner_next_in     = '0;
               frag_word_in      = '0;
               ident_word_in     = '0;
               decided_status_in = '0;
               decided_flag_in   = 1'b0;
            end
            KIND_END: begin
               if (!decided_flag_ff) begin
                  decided_status_in = end_status;
                  decided_flag_in   = 1'b1;
               end
               push.valid             = 1'b1;
               push.data.record_type  = 1'b1;
               push.data.status       = decided_flag_ff ? decided_status_ff : end_status;
               push.data.final_header = current_type_ff;
               push.data.walked_bytes = chain_offset_ff;
            end
            KIND_PAYLOAD: begin
               if (!decided_flag_ff && !past_cap) begin
                  if (byte_in_header_ff == 11'd0) begin
                     if (chk_hit) begin
                        decided_status_in = chk_status;
                        decided_flag_in   = 1'b1;
                     end else begin
                        frag_word_in      = '0;
                        ident_word_in     = '0;
                        inner_next_in     = req.data_byte;
                        if (is_frag)
                           current_length_in = FRAG_HDR_LEN;
                        byte_in_header_in = 11'd1;
                     end
                  end else begin
                     current_length_in = cur_len;
                     if (byte_in_header_ff == 11'd1 &&
                         {4'd0, cur_len} > budget_left) begin
                        decided_status_in = ST_LIMIT;
                        decided_flag_in   = 1'b1;
                     end else begin
                        if (is_frag && byte_in_header_ff != 11'd1) begin
                           if (byte_in_header_ff < 11'd4)
                              frag_word_in = {frag_word_ff[7:0], req.data_byte};
                           else if (byte_in_header_ff < 11'd8)
                              ident_word_in = {ident_word_ff[23:0], req.data_byte};
                        end
                        byte_in_header_in = bih_next[10:0];
                        if (hdr_done) begin
                           push.valid                 = 1'b1;
                           push.data.header_type      = current_type_ff;
                           push.data.following_header = inner_next_ff;
                           push.data.header_offset    = chain_offset_ff;
                           push.data.header_length    = cur_len;
                           if (is_frag) begin
                              push.data.frag_offset = frag_word_in[15:3];
                              push.data.more_frags  = frag_word_in[0];
                              push.data.frag_ident  = ident_word_in;
                           end
                           chain_offset_in   = chain_offset_ff + {4'd0, cur_len};
                           header_count_in   = header_count_ff + 8'd1;
                           current_type_in   = inner_next_ff;
                           byte_in_header_in = '0;
                           frag_word_in      = '0;
                           ident_word_in     = '0;
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_type_ff   <= '0;
         chain_offset_ff   <= '0;
         header_count_ff   <= '0;
         byte_in_header_ff <= '0;
         current_length_ff <= '0;
         inner_next_ff     <= '0;
         frag_word_ff      <= '0;
         ident_word_ff     <= '0;
         decided_status_ff <= '0;
         decided_flag_ff   <= 1'b0;
      end else begin
         current_type_ff   <= current_type_in;
         chain_offset_ff   <= chain_offset_in;
         header_count_ff   <= header_count_in;
         byte_in_header_ff <= byte_in_header_in;
         current_length_ff <= current_length_in;
         inner_next_ff     <= inner_next_in;
         frag_word_ff      <= frag_word_in;
         ident_word_ff     <= ident_word_in;
         decided_status_ff <= decided_status_in;
         decided_flag_ff   <= decided_flag_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/ipv6ecp_rsp_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module ipv6ecp_rsp_reg (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ipv6ecp_pkg::rsp_push_type push,
   output logic                           slot_free,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output ipv6ecp_pkg::rsp_type           rsp_data
);
   import ipv6ecp_pkg::*;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   // the slot can take a new item in the same cycle the old one drains
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (push.valid)
         rsp_valid_ff <= 1'b1;
      else if (rsp_ready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (push.valid)
         rsp_data_ff <= push.data;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: design/ipv6_extension_chain_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake                 Payload
// req      in         req_valid / req_ready     req_data  (kind, data_byte, first_header_type)
// rsp      out        rsp_valid / rsp_ready     rsp_data  (header or final status record)
// csr      in         csr_write                 csr_index, csr_wdata
//
// One item per cycle. A result shows on rsp in the cycle after the item giving it is taken.
// The walk state updates in the cycle of acceptance; the single result register
// sets the rate: req_ready drops only while a result is held and rsp_ready is low.
// Synchronous active-high reset: header_limit 8, byte_budget 2048, walk state cleared.

module ipv6_extension_chain_parser_top #(
   parameter int MAX_PAYLOAD_BYTES = 65535
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire ipv6ecp_pkg::req_type            req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output ipv6ecp_pkg::rsp_type                 rsp_data,
   input  wire logic                            csr_write,
   input  wire ipv6ecp_pkg::csr_index_type      csr_index,
   input  wire logic [ipv6ecp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ipv6ecp_pkg::*;

   csr_type      cfg;
   rsp_push_type push;
   logic         slot_free;
   logic         accept;

   assign req_ready = slot_free;
   assign accept    = req_valid && slot_free;

   ipv6ecp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ipv6ecp_walker #(
      .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
   ) u_walker (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg),
      .push   (push)
   );

   ipv6ecp_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // every end item yields a status record in the next cycle
   a_end_gives_status: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.kind == KIND_END) |=>
         (rsp_valid && rsp_data.record_type))
      else $error("end item did not produce a status record");

   // header records carry a real length and no status fields
   a_header_record_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.record_type) |->
         (rsp_data.header_length >= 12'd8 && rsp_data.status == ST_COMPLETE &&
          rsp_data.walked_bytes == 16'd0))
      else $error("malformed header record");

   // status records carry a defined status and no header fields
   a_status_record_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.record_type) |->
         (rsp_data.status <= ST_LIMIT && rsp_data.header_length == 12'd0 &&
          rsp_data.frag_ident == 32'd0))
      else $error("malformed status record");

endmodule

`default_nettype wire
